// ===== sv/rmts_pkg.sv =====
// Package with the shared codes and control structures of the rate-monotonic task scheduler.
`timescale 1ns / 1ps

package rmts_pkg;

    // Transaction kinds on the input channel.
    localparam logic [1:0] KIND_SCHED = 2'd0;
    localparam logic [1:0] KIND_ELECT = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_ZERO  = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // Which pass the slot scan is currently making.
    typedef enum logic [1:0] {
        PH_SCHED = 2'd0,
        PH_TICK  = 2'd1,
        PH_ELECT = 2'd2
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture an input transaction, clear the result
        logic elect_prep; // update the running task's ready bit, start an election
        logic read;       // read the slot tables at the scan index
        logic eval;       // evaluate the slot just read
        logic idx_inc;    // step the scan index
        logic finish;     // close the pass that has just ended
        logic emit;       // load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        phase_t     phase;
        logic       need;
        logic       last;
        logic       out_free;
    } sts_t;

endpackage

// ===== sv/rmts_ctrl.sv =====
// Controller state machine that sequences the slot scans of the scheduler.
`timescale 1ns / 1ps

module rmts_ctrl
    import rmts_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_EVAL  = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                end
            end
            ST_PREP: begin
                cmd.elect_prep = 1'b1;
                state_next     = ST_READ;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.last) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                if (sts.phase == PH_TICK && sts.need) begin
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_IDLE && s_tvalid) begin
            case (sts.kind)
                KIND_SCHED: state_next = ST_READ;
                KIND_TICK:  state_next = ST_READ;
                KIND_ELECT: state_next = ST_PREP;
                default:    state_next = ST_DONE;
            endcase
        end
    end

endmodule

// ===== sv/rmts_dp.sv =====
// Datapath of the scheduler: slot tables, scan registers and the output register.
`timescale 1ns / 1ps

module rmts_dp
    import rmts_pkg::*;
#(
    parameter int MAX_TASKS   = 16,
    parameter int PERIOD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  s_tuser,
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    input  cmd_t        cmd,
    output sts_t        sts
);

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int PB = PERIOD_BITS;
    localparam logic [SW-1:0] LAST_IDX = SW'(MAX_TASKS - 1);

    // Slot tables held in memories; only active slots are ever read for meaning.
    logic [31:0]  handle_mem [MAX_TASKS];
    logic [PB-1:0] period_mem [MAX_TASKS];
    logic [PB-1:0] cd_mem     [MAX_TASKS];
    logic [31:0]   rd_handle_reg;
    logic [PB-1:0] rd_period_reg;
    logic [PB-1:0] rd_cd_reg;

    logic [MAX_TASKS-1:0] active_reg, ready_reg;

    logic [31:0]   idle_reg;
    logic [31:0]   hin_reg;
    logic [PB-1:0] pin_reg;
    logic          still_reg;
    logic [15:0]   mask_reg;
    phase_t        phase_reg;
    logic [SW-1:0] idx_reg;

    logic          run_valid_reg;
    logic [SW-1:0] run_slot_reg;
    logic [31:0]   run_handle_reg;
    logic [PB-1:0] run_period_reg;

    logic          found_reg, free_found_reg, best_found_reg, need_reg;
    logic [SW-1:0] found_slot_reg, free_slot_reg, best_slot_reg;
    logic [PB-1:0] best_period_reg;
    logic [31:0]   best_handle_reg;

    logic [1:0]  res_status_reg;
    logic [3:0]  res_slot_reg;
    logic [31:0] res_el_handle_reg;
    logic        res_el_idle_reg, res_preempt_reg;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    // Per-slot evaluation of the tick pass, and the running task's new ready bit.
    logic [6:0]    idx_w, run_w;
    logic          mask_bit, run_mask_bit, cur_ready;
    logic [PB-1:0] cd_dec;
    logic          reload, rdy_new;

    always_comb begin
        idx_w        = 7'(idx_reg);
        run_w        = 7'(run_slot_reg);
        mask_bit     = (idx_w < 7'd16) && mask_reg[idx_w[3:0]];
        run_mask_bit = (run_w < 7'd16) && mask_reg[run_w[3:0]];
        cur_ready    = (phase_reg == PH_TICK) ? run_mask_bit : still_reg;
        cd_dec       = (rd_cd_reg != '0) ? rd_cd_reg - PB'(1) : rd_cd_reg;
        reload       = (cd_dec == '0);
        rdy_new      = ready_reg[idx_reg] | (reload & mask_bit);
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_handle_reg <= handle_mem[idx_reg];
            rd_period_reg <= period_mem[idx_reg];
            rd_cd_reg     <= cd_mem[idx_reg];
        end
        if (cmd.finish && phase_reg == PH_SCHED && !found_reg && free_found_reg
                && pin_reg != '0) begin
            handle_mem[free_slot_reg] <= hin_reg;
            period_mem[free_slot_reg] <= pin_reg;
            cd_mem[free_slot_reg]     <= pin_reg;
        end else if (cmd.eval && phase_reg == PH_TICK && active_reg[idx_reg]) begin
            cd_mem[idx_reg] <= reload ? rd_period_reg : cd_dec;
        end
    end

    // Scan and payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hin_reg           <= s_tdata[31:0];
            pin_reg           <= PB'(s_tdata[47:32]);
            still_reg         <= s_tdata[48];
            mask_reg          <= s_tdata[64:49];
            idx_reg           <= '0;
            found_reg         <= 1'b0;
            free_found_reg    <= 1'b0;
            need_reg          <= 1'b0;
            res_status_reg    <= STS_OK;
            res_slot_reg      <= '0;
            res_el_handle_reg <= '0;
            res_el_idle_reg   <= 1'b0;
            res_preempt_reg   <= 1'b0;
        end
        if (cmd.elect_prep) begin
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
        end
        if (cmd.idx_inc) begin
            idx_reg <= idx_reg + SW'(1);
        end
        if (cmd.eval) begin
            case (phase_reg)
                PH_SCHED: begin
                    if (active_reg[idx_reg] && rd_handle_reg == hin_reg && !found_reg) begin
                        found_reg      <= 1'b1;
                        found_slot_reg <= idx_reg;
                    end
                    if (!active_reg[idx_reg] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= idx_reg;
                    end
                end
                PH_TICK: begin
                    if (active_reg[idx_reg] && reload && rdy_new) begin
                        if (!run_valid_reg) begin
                            need_reg <= 1'b1;
                        end else if (idx_reg != run_slot_reg
                                && rd_period_reg < run_period_reg) begin
                            need_reg <= 1'b1;
                        end
                    end
                end
                PH_ELECT: begin
                    if (active_reg[idx_reg] && ready_reg[idx_reg]
                            && (!best_found_reg || rd_period_reg < best_period_reg)) begin
                        best_found_reg  <= 1'b1;
                        best_slot_reg   <= idx_reg;
                        best_period_reg <= rd_period_reg;
                        best_handle_reg <= rd_handle_reg;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.finish) begin
            case (phase_reg)
                PH_SCHED: begin
                    if (found_reg) begin
                        res_slot_reg <= 4'(found_slot_reg);
                    end else if (!free_found_reg) begin
                        res_status_reg <= STS_FULL;
                    end else if (pin_reg == '0) begin
                        res_status_reg <= STS_ZERO;
                    end else begin
                        res_slot_reg <= 4'(free_slot_reg);
                    end
                end
                PH_TICK: begin
                    res_preempt_reg <= need_reg;
                end
                PH_ELECT: begin
                    res_el_handle_reg <= best_found_reg ? best_handle_reg : idle_reg;
                    res_el_idle_reg   <= !best_found_reg;
                    run_slot_reg      <= best_slot_reg;
                    run_handle_reg    <= best_handle_reg;
                    run_period_reg    <= best_period_reg;
                end
                default: ;
            endcase
        end
        if (cmd.emit) begin
            m_tdata_reg <= {run_valid_reg ? run_handle_reg : idle_reg, res_preempt_reg,
                            res_el_idle_reg, res_el_handle_reg, res_slot_reg,
                            res_status_reg};
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg      <= '0;
            active_reg    <= '0;
            ready_reg     <= '0;
            run_valid_reg <= 1'b0;
            phase_reg     <= PH_SCHED;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                idle_reg <= cfg_wdata;
            end
            if (cmd.load) begin
                phase_reg <= (s_tuser == KIND_ELECT) ? PH_ELECT :
                             (s_tuser == KIND_TICK)  ? PH_TICK  : PH_SCHED;
            end
            if (cmd.elect_prep) begin
                phase_reg <= PH_ELECT;
                if (run_valid_reg) begin
                    ready_reg[run_slot_reg] <= cur_ready;
                end
            end
            if (cmd.eval && phase_reg == PH_TICK && active_reg[idx_reg]) begin
                ready_reg[idx_reg] <= rdy_new;
            end
            if (cmd.finish && phase_reg == PH_SCHED) begin
                if (found_reg) begin
                    ready_reg[found_slot_reg] <= 1'b1;
                end else if (free_found_reg && pin_reg != '0) begin
                    active_reg[free_slot_reg] <= 1'b1;
                    ready_reg[free_slot_reg]  <= 1'b1;
                end
            end
            if (cmd.finish && phase_reg == PH_ELECT) begin
                run_valid_reg <= best_found_reg;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign sts.kind     = s_tuser;
    assign sts.phase    = phase_reg;
    assign sts.need     = need_reg;
    assign sts.last     = (idx_reg == LAST_IDX);
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule

// ===== sv/rate_monotonic_task_scheduler_top.sv =====
// Top level of the rate-monotonic task scheduler: controller and datapath.
`timescale 1ns / 1ps

// Channel      Direction  Contents
// s_  input    in         tuser: kind; tdata: handle, period, still-ready flag, ready mask
// m_  result   out        tdata: status, slot, elected handle and idle flag, preempt, running
// cfg_         in         write enable and data of the idle handle register
//
// Each input transaction of a known kind is worked by a scan over all task slots,
// each slot being read from memory and then evaluated. An elect first updates the
// running task's ready bit; a preempting tick is followed by an election scan, and
// a transaction of unknown kind goes straight to the result with no scan.
// The slot memories have a single read port, so the slots are scanned one at a time.
// Reset (aresetn, synchronous, active low) clears the active and ready bits and
// the running task; slot memories need no clearing pass. A result waiting on a
// stalled master side does not stop the next input transaction being taken.
module rate_monotonic_task_scheduler_top
    import rmts_pkg::*;
#(
    parameter int MAX_TASKS   = 16,
    parameter int PERIOD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // [31:0] task_handle, [47:32] task_period, [48] current_still_ready,
    // [64:49] ready_state_mask, [71:65] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [5:2] task_slot, [37:6] elected_handle, [38] elected_idle,
    // [39] preempt, [71:40] running_handle
    output logic [71:0] m_tdata,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    rmts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rmts_dp #(
        .MAX_TASKS   (MAX_TASKS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
